### sv/gamepad_frame_deframer_top_assert.svh
// Assertion macros for the gamepad frame deframer.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef GAMEPAD_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define GAMEPAD_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, ignored while reset is high
`define GFD_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check that also holds during reset
`define GFD_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GFD_ASSERT(lbl, clock, reset, prop, msg)
`define GFD_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### sv/gfd_pkg.sv
// Shared constants and types for the gamepad frame deframer.
// No dependencies.
`default_nettype none

package gfd_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hA5;
  localparam logic [7:0] TAIL_BYTE   = 8'hA6;
  localparam int         FRAME_BYTES = 16;           // data bytes between header and tail
  localparam int         POS_W       = 5;            // holds 0..FRAME_BYTES
  localparam logic [POS_W-1:0] TAIL_POS = POS_W'(FRAME_BYTES);
  localparam int         IDX_W       = $clog2(FRAME_BYTES);

  // status codes
  localparam logic STATUS_GOOD     = 1'b0;
  localparam logic STATUS_BAD_TAIL = 1'b1;

  // bit positions of buttons in the raw frame bytes
  localparam int B14_A     = 0;
  localparam int B14_B     = 1;
  localparam int B14_X     = 3;
  localparam int B14_Y     = 4;
  localparam int B14_LB    = 6;
  localparam int B14_RB    = 7;
  localparam int B15_VIEW  = 2;
  localparam int B15_MENU  = 3;
  localparam int B15_GUIDE = 4;
  localparam int B15_LPRS  = 5;
  localparam int B15_RPRS  = 6;
  localparam int B16_SHARE = 0;

  // frame data bytes 1..16 held at index 0..15
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic        frame_status;
    logic [15:0] left_stick_x;
    logic [15:0] left_stick_y;
    logic [15:0] right_stick_x;
    logic [15:0] right_stick_y;
    logic [15:0] left_trigger;
    logic [15:0] right_trigger;
    logic [7:0]  stick_combination;
    logic [11:0] button_bits;
  } result_t;

endpackage

`default_nettype wire

### sv/gfd_decode.sv
// Frame field decode: tail check, axis assembly and button remap.
// Depends on gfd_pkg.
`default_nettype none

module gfd_decode
  import gfd_pkg::*;
(
  input  frame_t     frame,
  input  logic [7:0] tail,
  output result_t    result
);

  logic [11:0] buttons;

  always_comb begin
    buttons     = '0;
    buttons[0]  = frame[13][B14_A];
    buttons[1]  = frame[13][B14_B];
    buttons[2]  = frame[13][B14_X];
    buttons[3]  = frame[13][B14_Y];
    buttons[4]  = frame[13][B14_LB];
    buttons[5]  = frame[13][B14_RB];
    buttons[6]  = frame[14][B15_VIEW];
    buttons[7]  = frame[14][B15_MENU];
    buttons[8]  = frame[14][B15_GUIDE];
    buttons[9]  = frame[14][B15_LPRS];
    buttons[10] = frame[14][B15_RPRS];
    buttons[11] = frame[15][B16_SHARE];
  end

  always_comb begin
    result = '0;
    if (tail != TAIL_BYTE) begin
      result.frame_status = STATUS_BAD_TAIL;
    end else begin
      result.frame_status      = STATUS_GOOD;
      result.left_stick_x      = {frame[1],  frame[0]};
      result.left_stick_y      = {frame[3],  frame[2]};
      result.right_stick_x     = {frame[5],  frame[4]};
      result.right_stick_y     = {frame[7],  frame[6]};
      result.left_trigger      = {frame[9],  frame[8]};
      result.right_trigger     = {frame[11], frame[10]};
      result.stick_combination = frame[12];
      result.button_bits       = buttons;
    end
  end

endmodule

`default_nettype wire

### sv/gamepad_frame_deframer_top.sv
// Gamepad frame deframer. Throughput: one byte word per cycle, except while in_stall holds the tail.
// Latency: a result word appears on the outputs the cycle after its tail byte is taken.
// Input stalls only in the tail slot while the previous result waits under out_stall.
// Reset (rst, synchronous, active high): back to hunting, no result pending.
// Frame store is not cleared; every entry is rewritten before each tail.
`default_nettype none

`include "gamepad_frame_deframer_top_assert.svh"

module gamepad_frame_deframer_top
  import gfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // decoded frames out
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_status,
  output logic [15:0] left_stick_x,
  output logic [15:0] left_stick_y,
  output logic [15:0] right_stick_x,
  output logic [15:0] right_stick_y,
  output logic [15:0] left_trigger,
  output logic [15:0] right_trigger,
  output logic [7:0]  stick_combination,
  output logic [11:0] button_bits
);

  // ---------------------------------------------------------------
  // Framing state
  //   collecting    : header seen, taking data bytes
  //   byte_position : data bytes taken since the header (0..16);
  //                   at 16 the next byte is the tail
  //   frame_store   : data bytes 1..16
  // ---------------------------------------------------------------
  logic             collecting;
  logic [POS_W-1:0] byte_position;
  frame_t           frame_store;

  // result holding register
  result_t res;
  result_t decoded;

  logic in_take;
  logic at_tail;
  logic load;

  // The next byte is the tail when all data bytes are in.
  assign at_tail = collecting && (byte_position == TAIL_POS);

  // Only a tail word needs the output slot; hunting and data bytes
  // flow on even while a result waits downstream.
  assign in_stall = at_tail && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign load     = in_take && at_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      byte_position <= '0;
    end else if (in_take) begin
      if (!collecting) begin
        // hunting: anything but the header is dropped
        if (rx_byte == HDR_BYTE) begin
          collecting    <= 1'b1;
          byte_position <= '0;
        end
      end else if (at_tail) begin
        // good or bad, hunting resumes with the next byte
        collecting    <= 1'b0;
        byte_position <= '0;
      end else begin
        // data byte; a header value here is plain data
        byte_position <= byte_position + POS_W'(1);
      end
    end
  end

  // data store needs no reset
  always_ff @(posedge clk) begin
    if (in_take && collecting && !at_tail) begin
      frame_store[byte_position[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Decode straight off the store and the incoming tail byte.
  gfd_decode u_decode (
    .frame  (frame_store),
    .tail   (rx_byte),
    .result (decoded)
  );

  // Output register: loads on a tail, drops once taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= decoded;
    end
  end

  assign frame_status      = res.frame_status;
  assign left_stick_x      = res.left_stick_x;
  assign left_stick_y      = res.left_stick_y;
  assign right_stick_x     = res.right_stick_x;
  assign right_stick_y     = res.right_stick_y;
  assign left_trigger      = res.left_trigger;
  assign right_trigger     = res.right_trigger;
  assign stick_combination = res.stick_combination;
  assign button_bits       = res.button_bits;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `GFD_ASSERT(a_pos_idle_zero, clk, rst, !collecting |-> byte_position == '0, "position set while hunting")
  `GFD_ASSERT(a_stall_tail_only, clk, rst, in_stall |-> at_tail, "input stalled off the tail")
  `GFD_ASSERT(a_tail_gives_word, clk, rst, load |=> out_valid, "tail accepted without result")
  // every field below the status bit is zero on a bad tail
  `GFD_ASSERT_ALWAYS(a_bad_zeroed, clk,
    (out_valid && frame_status == STATUS_BAD_TAIL) |-> (res[$bits(res)-2:0] == '0),
    "bad tail result not zeroed")

endmodule

`default_nettype wire
